[sv/assert_macros.svh]
// Assertion macros shared by the modules of the hazard NOP inserter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, when true, forces another one at the following edge.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[sv/rhni_pkg.sv]
// Types and constants of the RV32I hazard NOP inserter.
`default_nettype none

package rhni_pkg;

    localparam logic [31:0] NOP_WORD = 32'h0000_0013;

    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

    localparam logic [4:0] REG_X0 = 5'b00000;

    // Index of the forwarding mode register on the configuration port.
    localparam logic REG_IDX_FWD_MODE = 1'b0;

    // One classified instruction: the word and how many NOPs go before it.
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  nops;
    } entry_t;

endpackage

`default_nettype wire

[sv/rhni_front.sv]
// Front end: decodes each instruction, checks it against the write history and counts NOPs.
`default_nettype none

module rhni_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fwd_mode,
    input  wire logic            accept,
    input  wire logic [31:0]     instr_word,
    output rhni_pkg::entry_t     entry
);
    import rhni_pkg::*;

    `include "assert_macros.svh"

    logic [4:0] d1_dest_reg;
    logic       d1_writes_reg;
    logic       d1_is_load_reg;
    logic [4:0] d2_dest_reg;
    logic       d2_writes_reg;

    logic [6:0] opc;
    logic [4:0] rd;
    logic [4:0] rs1;
    logic [4:0] rs2;
    logic       use1;
    logic       use2;
    logic       writes;
    logic       hit_d1;
    logic       hit_d2;
    logic [1:0] nops;

    assign opc = instr_word[6:0];
    assign rd  = instr_word[11:7];
    assign rs1 = instr_word[19:15];
    assign rs2 = instr_word[24:20];

    always_comb
    begin
        use1   = 1'b0;
        use2   = 1'b0;
        writes = 1'b0;
        case (opc)
            OPC_OP:
            begin
                use1   = 1'b1;
                use2   = 1'b1;
                writes = 1'b1;
            end
            OPC_STORE, OPC_BRANCH:
            begin
                use1 = 1'b1;
                use2 = 1'b1;
            end
            OPC_OPIMM, OPC_SYSTEM, OPC_LOAD, OPC_JALR:
            begin
                use1   = 1'b1;
                writes = 1'b1;
            end
            OPC_JAL, OPC_LUI, OPC_AUIPC:
            begin
                writes = 1'b1;
            end
            default:
            begin
                use1   = 1'b0;
            end
        endcase
    end

    // The history only ever records writers with a non-zero destination.
    assign hit_d1 = d1_writes_reg &&
                    ((use1 && d1_dest_reg == rs1) || (use2 && d1_dest_reg == rs2));
    assign hit_d2 = d2_writes_reg &&
                    ((use1 && d2_dest_reg == rs1) || (use2 && d2_dest_reg == rs2));

    always_comb
    begin
        if (fwd_mode)
        begin
            nops = (d1_is_load_reg && hit_d1) ? 2'd1 : 2'd0;
        end
        else if (hit_d1)
        begin
            nops = 2'd2;
        end
        else if (hit_d2)
        begin
            nops = 2'd1;
        end
        else
        begin
            nops = 2'd0;
        end
    end

    assign entry.word = instr_word;
    assign entry.nops = nops;

    // Any inserted NOP pushes the older writer out of the two-deep window,
    // so the word before this one is only kept when no NOP goes between.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_dest_reg    <= REG_X0;
            d1_writes_reg  <= 1'b0;
            d1_is_load_reg <= 1'b0;
            d2_dest_reg    <= REG_X0;
            d2_writes_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (nops == 2'd0)
            begin
                d2_dest_reg   <= d1_dest_reg;
                d2_writes_reg <= d1_writes_reg;
            end
            else
            begin
                d2_dest_reg   <= REG_X0;
                d2_writes_reg <= 1'b0;
            end
            d1_dest_reg    <= rd;
            d1_writes_reg  <= writes && (rd != REG_X0);
            d1_is_load_reg <= writes && (rd != REG_X0) && (opc == OPC_LOAD);
        end
    end

    `ASSERT_NEXT(a_nop_clears_d2, accept && nops != 2'd0, !d2_writes_reg,
                 "older writer survived an inserted NOP")
    `ASSERT_ALWAYS(a_x0_never_recorded, !(d1_writes_reg && d1_dest_reg == REG_X0),
                   "a write to x0 was recorded in the history")

endmodule

`default_nettype wire

[sv/rhni_queue.sv]
// Short queue of classified instructions between the front and the back end.
`default_nettype none

module rhni_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire rhni_pkg::entry_t push_entry,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output rhni_pkg::entry_t     head_entry
);
    import rhni_pkg::*;

    `include "assert_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, !(push && full), "push into a full queue")
    `ASSERT_ALWAYS(a_no_underflow, !(pop && !head_valid), "pop from an empty queue")

endmodule

`default_nettype wire

[sv/rhni_back.sv]
// Back end: expands each queued instruction into its NOPs and the word itself.
`default_nettype none

module rhni_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            head_valid,
    input  wire rhni_pkg::entry_t head_entry,
    output logic                 head_pop,
    input  wire logic            pop,
    output logic                 empty,
    output logic [31:0]          out_word,
    output logic                 is_bubble,
    output logic                 last_of_run
);
    import rhni_pkg::*;

    `include "assert_macros.svh"

    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic        is_bubble_reg;
    logic        last_reg;
    logic [1:0]  nop_done_reg;
    logic        out_free;
    logic        emit;
    logic        emit_nop;

    assign out_free = !out_valid_reg || pop;
    assign emit     = out_free && head_valid;
    assign emit_nop = nop_done_reg < head_entry.nops;
    assign head_pop = emit && !emit_nop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            nop_done_reg  <= 2'd0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= head_valid;
            end
            if (emit)
            begin
                nop_done_reg <= emit_nop ? nop_done_reg + 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_word_reg  <= emit_nop ? NOP_WORD : head_entry.word;
            is_bubble_reg <= emit_nop;
            last_reg      <= !emit_nop;
        end
    end

    assign empty       = !out_valid_reg;
    assign out_word    = out_word_reg;
    assign is_bubble   = is_bubble_reg;
    assign last_of_run = last_reg;

    `ASSERT_ALWAYS(a_bubble_xor_last, !out_valid_reg || (is_bubble_reg != last_reg),
                   "result beat is both or neither a NOP and a run end")
    `ASSERT_NEXT(a_stalled_result_holds, out_valid_reg && !pop,
                 out_valid_reg && $stable(out_word_reg) && $stable(last_reg),
                 "waiting result changed while the receiver stalled")

endmodule

`default_nettype wire

[sv/rv32_hazard_nop_inserter.sv]
// Top level of the RV32I read-after-write hazard NOP inserter.
//
// Instruction words enter on a queue-style input: a beat is taken at a rising
// edge where push is high and full is low. Results leave on a queue-style
// output: while empty is low the oldest result is on out_word, is_bubble and
// last_of_run, and it is taken at an edge where pop is high.
// Each instruction produces zero, one or two NOP beats (addi x0,x0,0, with
// is_bubble set) followed by the instruction itself (with last_of_run set).
// The front end decodes and checks hazards in the cycle of acceptance and
// updates its write history at once; a two-entry queue then feeds the back
// end, which expands one entry into its beats, one beat per cycle while the
// receiver takes them. Throughput is one instruction per cycle when no NOPs
// are needed and the receiver keeps up; an instruction that needs NOPs holds
// the back end for its whole run, and full rises once the queue has filled
// behind it. When the receiver stalls, the result register holds its beat and
// the queue fills and raises full. Reset clears the history (no earlier
// writers), empties the queue and sets the forwarding mode to zero (no
// forwarding). The user writes the mode through the APB port at byte address
// 0 only while the block is idle; the block itself does not enforce this.
`default_nettype none

module rv32_hazard_nop_inserter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Instruction input
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] instr_word,
    // Result output
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      out_word,
    output logic             is_bubble,
    output logic             last_of_run,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rhni_pkg::*;

    logic   fwd_mode_reg;
    logic   cfg_write;
    logic   in_accept;
    logic   q_full;
    logic   q_head_valid;
    logic   q_pop;
    entry_t front_entry;
    entry_t q_head_entry;

    // Register index is the word address; only the mode register exists.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_mode_reg <= 1'b0;
        end
        else if (cfg_write && paddr[2] == REG_IDX_FWD_MODE)
        begin
            fwd_mode_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_IDX_FWD_MODE) ? {31'd0, fwd_mode_reg} : 32'd0;

    // The queue's free space is the only thing that holds off new beats.
    assign full      = q_full;
    assign in_accept = push && !q_full;

    rhni_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .fwd_mode   (fwd_mode_reg),
        .accept     (in_accept),
        .instr_word (instr_word),
        .entry      (front_entry)
    );

    rhni_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_accept),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    rhni_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_head_valid),
        .head_entry  (q_head_entry),
        .head_pop    (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_word    (out_word),
        .is_bubble   (is_bubble),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the RV32I hazard NOP inserter.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rhni_pkg::*;

    // A custom-0 opcode, which the block must pass through as reading and writing nothing.
    localparam logic [6:0] OPC_CUSTOM0   = 7'b0001011;
    localparam logic [2:0] FWD_MODE_ADDR = {REG_IDX_FWD_MODE, 2'b00};
    localparam int         HOLD_CYCLES   = 150;
    localparam int         CYCLE_LIMIT   = 100000;

    // One result beat as it should appear on the output side.
    typedef struct packed {
        logic [31:0] word;
        logic        bubble;
        logic        last_beat;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] instr_word = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] out_word;
    logic        is_bubble;
    logic        last_of_run;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rv32_hazard_nop_inserter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .instr_word  (instr_word),
        .empty       (empty),
        .pop         (pop),
        .out_word    (out_word),
        .is_bubble   (is_bubble),
        .last_of_run (last_of_run),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 clk = ~clk;

    // Instruction words still to be offered, and the beats the block owes us.
    logic [31:0] pending_words[$];
    beat_t       expected_beats[$];
    int          error_count = 0;
    int          cycle_count = 0;

    // Appends one word to the stimulus list.
    task automatic add_word(input logic [31:0] w);
        pending_words = {pending_words, w};
    endtask

    // Appends one beat to the list of beats still owed by the block.
    task automatic owe_beat(input beat_t b);
        expected_beats = {expected_beats, b};
    endtask

    // Idling controls, changed between phases by the stimulus process.
    int          send_gap_max = 0;
    int          take_gap_max = 0;
    logic        hold_request = 1'b0;

    // Our own view of the forwarding mode and of the last two emitted words.
    logic        fwd_mode = 1'b0;
    logic [4:0]  last_rd = REG_X0;
    logic        last_writes = 1'b0;
    logic        last_is_load = 1'b0;
    logic [4:0]  prev_rd = REG_X0;
    logic        prev_writes = 1'b0;

    // True when an earlier word wrote a register that this word reads.
    function automatic logic hits(input logic writes, input logic [4:0] dest,
                                  input logic reads1, input logic [4:0] rs1,
                                  input logic reads2, input logic [4:0] rs2);
        if (!writes || dest == REG_X0)
            return 1'b0;
        return (reads1 && dest == rs1) || (reads2 && dest == rs2);
    endfunction

    // Every emitted word, inserted NOPs included, ages the history by one.
    task automatic shift_history(input logic writes, input logic [4:0] dest,
                                 input logic is_load);
        prev_rd      = last_rd;
        prev_writes  = last_writes;
        last_rd      = dest;
        last_writes  = writes && dest != REG_X0;
        last_is_load = last_writes && is_load;
    endtask

    // Works out the NOP run and the original word for one accepted instruction.
    task automatic expand_instr(input logic [31:0] w);
        logic [6:0] opc;
        logic [4:0] rd;
        logic [4:0] rs1;
        logic [4:0] rs2;
        logic       reads1;
        logic       reads2;
        logic       writes;
        int         nops;
        opc    = w[6:0];
        rd     = w[11:7];
        rs1    = w[19:15];
        rs2    = w[24:20];
        reads1 = 1'b0;
        reads2 = 1'b0;
        writes = 1'b0;
        nops   = 0;
        case (opc)
            OPC_OP:
            begin
                reads1 = 1'b1;
                reads2 = 1'b1;
                writes = 1'b1;
            end
            OPC_STORE, OPC_BRANCH:
            begin
                reads1 = 1'b1;
                reads2 = 1'b1;
            end
            OPC_OPIMM, OPC_SYSTEM, OPC_LOAD, OPC_JALR:
            begin
                reads1 = 1'b1;
                writes = 1'b1;
            end
            OPC_JAL, OPC_LUI, OPC_AUIPC:
            begin
                writes = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (!fwd_mode)
        begin
            // Without forwarding the distance to the writer sets the run length.
            if (hits(last_writes, last_rd, reads1, rs1, reads2, rs2))
                nops = 2;
            else if (hits(prev_writes, prev_rd, reads1, rs1, reads2, rs2))
                nops = 1;
        end
        else if (last_is_load && hits(last_writes, last_rd, reads1, rs1, reads2, rs2))
        begin
            // With forwarding only a load directly ahead costs a bubble.
            nops = 1;
        end
        repeat (nops)
        begin
            owe_beat(beat_t'{NOP_WORD, 1'b1, 1'b0});
            shift_history(1'b0, REG_X0, 1'b0);
        end
        owe_beat(beat_t'{w, 1'b0, 1'b1});
        shift_history(writes, rd, opc == OPC_LOAD);
    endtask

    // An instruction word with the given fields and random bits everywhere else.
    function automatic logic [31:0] build_word(input logic [6:0] opc, input logic [4:0] rd,
                                               input logic [4:0] rs1, input logic [4:0] rs2);
        logic [31:0] w;
        w        = $urandom();
        w[6:0]   = opc;
        w[11:7]  = rd;
        w[19:15] = rs1;
        w[24:20] = rs2;
        return w;
    endfunction

    // Mostly a handful of low registers, so that dependences are frequent.
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 7) == 0)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, 3));
    endfunction

    // Queues random instructions: nearly all carry a known opcode, a few are noise.
    task automatic queue_random(input int count);
        logic [6:0] known_opcodes[10];
        logic [6:0] opc;
        known_opcodes = '{OPC_LOAD, OPC_OPIMM, OPC_AUIPC, OPC_STORE, OPC_OP,
                          OPC_LUI, OPC_BRANCH, OPC_JALR, OPC_JAL, OPC_SYSTEM};
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
                opc = 7'($urandom());
            else
                opc = known_opcodes[$urandom_range(0, 9)];
            add_word(build_word(opc, pick_reg(), pick_reg(), pick_reg()));
        end
    endtask

    // Setup beat, then the access beat; the register takes the value once pready is seen.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == FWD_MODE_ADDR)
            fwd_mode = data[0];
    endtask

    // The block is idle once every word has gone in and every beat has come out.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || push || expected_beats.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Driver: offers the next pending word after a random gap and holds it until taken.
    // Prediction happens at the edge of acceptance, when the word is known to be in.
    int send_wait = 0;

    always @(posedge clk)
    begin : driver
        logic next_push;
        if (rst_n)
        begin
            next_push = push;
            if (push && !full)
            begin
                expand_instr(instr_word);
                next_push = 1'b0;
                send_wait = $urandom_range(0, send_gap_max);
            end
            if (!next_push)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (pending_words.size() != 0)
                begin
                    instr_word <= pending_words.pop_front();
                    next_push = 1'b1;
                end
            end
            push <= next_push;
        end
    end

    // Monitor: takes beats after a random stall and compares them with the oldest
    // expected beat. Once asked, it also holds off for a long stretch of its own.
    int take_wait = 0;
    int hold_left = 0;

    always @(posedge clk)
    begin : monitor
        logic  next_pop;
        beat_t want;
        if (rst_n)
        begin
            next_pop = pop;
            if (pop && !empty)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: unexpected beat: expected none, actual word %h bubble %b last %b",
                             $time, out_word, is_bubble, last_of_run);
                    error_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (out_word !== want.word)
                    begin
                        $display("%0t: out_word mismatch: expected %h, actual %h",
                                 $time, want.word, out_word);
                        error_count++;
                    end
                    if (is_bubble !== want.bubble)
                    begin
                        $display("%0t: is_bubble mismatch: expected %b, actual %b",
                                 $time, want.bubble, is_bubble);
                        error_count++;
                    end
                    if (last_of_run !== want.last_beat)
                    begin
                        $display("%0t: last_of_run mismatch: expected %b, actual %b",
                                 $time, want.last_beat, last_of_run);
                        error_count++;
                    end
                end
                next_pop  = 1'b0;
                take_wait = $urandom_range(0, take_gap_max);
            end
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_pop = 1'b0;
            end
            else if (!next_pop)
            begin
                if (take_wait > 0)
                    take_wait--;
                else
                    next_pop = 1'b1;
            end
            pop <= next_pop;
        end
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL rv32_hazard_nop_inserter");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed words without forwarding. Both sides idle at random.
        send_gap_max = 14;
        take_gap_max = 14;
        apb_write(FWD_MODE_ADDR, 32'd0);
        @(negedge clk);
        add_word(32'h0000_0000);
        add_word(32'hFFFF_FFFF);
        add_word(build_word(OPC_OP, 5'd5, 5'd1, 5'd2));
        // rs1 on the word just emitted: two bubbles.
        add_word(build_word(OPC_OP, 5'd6, 5'd5, 5'd0));
        add_word(build_word(OPC_LOAD, 5'd7, 5'd3, 5'd0));
        // A store reading the load through rs2; its rd field is immediate bits.
        add_word(build_word(OPC_STORE, 5'd9, 5'd0, 5'd7));
        add_word(build_word(OPC_OPIMM, 5'd8, 5'd0, 5'd0));
        add_word(build_word(OPC_LUI, 5'd9, 5'd0, 5'd0));
        // A branch on the writer two back gets one bubble, and writes nothing itself.
        add_word(build_word(OPC_BRANCH, 5'd9, 5'd8, 5'd0));
        // The bubble before the branch has pushed the LUI out of reach.
        add_word(build_word(OPC_OP, 5'd10, 5'd9, 5'd9));
        // A write to x0 is never a hazard, nor is a read of x0.
        add_word(build_word(OPC_AUIPC, 5'd0, 5'd0, 5'd0));
        add_word(build_word(OPC_OP, 5'd11, 5'd0, 5'd0));
        add_word(build_word(OPC_JAL, 5'd1, 5'd0, 5'd0));
        add_word(build_word(OPC_JALR, 5'd2, 5'd1, 5'd0));
        add_word(build_word(OPC_SYSTEM, 5'd3, 5'd2, 5'd0));
        // An unknown opcode reads nothing, even with matching source fields.
        add_word(build_word(OPC_CUSTOM0, 5'd12, 5'd3, 5'd3));
        // R-type rs2 against the writer two back.
        add_word(build_word(OPC_OP, 5'd14, 5'd0, 5'd3));
        wait_until_drained();

        // Directed words with forwarding; the history carries over the mode change.
        send_gap_max = 0;
        take_gap_max = 5;
        apb_write(FWD_MODE_ADDR, 32'd1);
        @(negedge clk);
        add_word(build_word(OPC_LOAD, 5'd20, 5'd1, 5'd0));
        // Load-use through rs2.
        add_word(build_word(OPC_OP, 5'd21, 5'd0, 5'd20));
        add_word(build_word(OPC_LOAD, 5'd22, 5'd1, 5'd0));
        add_word(build_word(OPC_OPIMM, 5'd0, 5'd0, 5'd0));
        // A load two back is forwarded, as is an ALU result directly ahead.
        add_word(build_word(OPC_OP, 5'd23, 5'd22, 5'd22));
        add_word(build_word(OPC_OPIMM, 5'd24, 5'd23, 5'd0));
        add_word(build_word(OPC_LOAD, 5'd0, 5'd24, 5'd0));
        add_word(build_word(OPC_BRANCH, 5'd0, 5'd0, 5'd0));
        // A load followed by a jump, which reads no register.
        add_word(build_word(OPC_LOAD, 5'd25, 5'd0, 5'd0));
        add_word(build_word(OPC_JAL, 5'd26, 5'd25, 5'd25));
        wait_until_drained();

        // Random words without forwarding. The receiver holds off for a long stretch
        // while the sender keeps offering, so the block fills and raises full.
        send_gap_max = 14;
        take_gap_max = 0;
        apb_write(FWD_MODE_ADDR, 32'd0);
        @(negedge clk);
        hold_request = 1'b1;
        queue_random(35);
        wait_until_drained();

        // Random words with forwarding, back to back with no idling at all.
        send_gap_max = 0;
        take_gap_max = 0;
        apb_write(FWD_MODE_ADDR, 32'd1);
        @(negedge clk);
        queue_random(35);
        wait_until_drained();

        // Random words without forwarding against a slow receiver.
        send_gap_max = 2;
        take_gap_max = 14;
        apb_write(FWD_MODE_ADDR, 32'd0);
        @(negedge clk);
        queue_random(33);
        wait_until_drained();

        repeat (10) @(negedge clk);
        if (error_count == 0)
            $display("PASS rv32_hazard_nop_inserter");
        else
            $display("FAIL rv32_hazard_nop_inserter");
        $finish;
    end

endmodule
